// ===== rtl/fts_pkg.sv =====
`timescale 1ns / 1ps

package fts_pkg;

    // Parse position within the file
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PREV    = 2'd1,
        PH_TAG     = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    // What the beat completed
    typedef enum logic [2:0] {
        KIND_CONSUMED = 3'd0,
        KIND_HEADER   = 3'd1,
        KIND_PREV     = 3'd2,
        KIND_TAG      = 3'd3,
        KIND_PAYLOAD  = 3'd4
    } kind_t;

    // Last byte index of each fixed-length section
    localparam logic [3:0] HEADER_LAST_IDX = 4'd8;
    localparam logic [3:0] PREV_LAST_IDX   = 4'd3;
    localparam logic [3:0] TAG_LAST_IDX    = 4'd10;

    localparam int DATA_W = 200;

    typedef struct packed {
        kind_t        kind;
        logic         payload_last;
        logic [7:0]   payload_byte;
        logic [23:0]  stream_id;
        logic [31:0]  timestamp;
        logic [23:0]  data_size;
        logic [7:0]   tag_type;
        logic [31:0]  prev_tag_size;
        logic [31:0]  header_length;
        logic [7:0]   flags;
        logic [7:0]   version;
        logic [23:0]  signature;
    } result_t;

endpackage

// ===== rtl/flv_tag_stream_parser.sv =====
`timescale 1ns / 1ps

// FLV tag stream parser.
// Input: one file byte per beat on s_axis (tdata[7:0]), starting at the first
// byte of the 9-byte file header. Output: exactly one beat per input beat on
// m_axis. tuser carries the kind (consumed, header done, previous size done,
// tag header done, payload byte); tdata carries the decoded fields, all zero
// except those the kind reports; tlast marks the final payload byte of a tag.
// The byte is decoded by combinational logic from the parse state and lands
// in the output register on the accepting edge. Throughput is one byte per
// cycle while m_axis_tready is high, set by the single output register: a
// new byte is taken whenever the output register is empty or being drained.
// When the receiver stalls (m_axis_tready low) the result holds in the output
// register and s_axis_tready drops until it is taken; no beat is lost.
// Reset (rst_n low, asynchronous) returns the parser to the start of the file
// header, clears all held fields and empties the output register.
// There is no end-of-file handling; the parser waits for more bytes.
module flv_tag_stream_parser
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,   // data_byte[7:0]
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // signature[23:0], version[31:24], flags[39:32], header_length[71:40],
    // prev_tag_size[103:72], tag_type[111:104], data_size[135:112],
    // timestamp[167:136], stream_id[191:168], payload_byte[199:192]
    output logic [fts_pkg::DATA_W-1:0] m_axis_tdata,
    output logic [2:0]               m_axis_tuser,   // kind[2:0]
    output logic                     m_axis_tlast    // payload_last
);
    import fts_pkg::*;

    phase_t       phase_reg, phase_next;
    logic [3:0]   index_reg, index_next;
    logic [23:0]  shift_reg, shift_next;
    logic [23:0]  sig_reg, sig_next;
    logic [7:0]   version_reg, version_next;
    logic [7:0]   flags_reg, flags_next;
    logic [7:0]   tag_type_reg, tag_type_next;
    logic [23:0]  data_size_reg, data_size_next;
    logic [23:0]  ts_reg, ts_next;
    logic [7:0]   ts_ext_reg, ts_ext_next;
    logic [23:0]  remaining_reg, remaining_next;
    logic         out_valid_reg, out_valid_next;
    result_t      out_reg, out_next;

    logic         in_fire;
    logic         shift_clear;
    logic [31:0]  shift_new;
    logic [23:0]  remaining_dec;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Find field starts where the shift register restarts
    always_comb
    begin
        shift_clear = 1'b0;
        case (phase_reg)
            PH_HEADER:  shift_clear = (index_reg inside {4'd0, 4'd5});
            PH_PREV:    shift_clear = (index_reg == 4'd0);
            PH_TAG:     shift_clear = (index_reg inside {4'd1, 4'd4, 4'd8});
            default:    shift_clear = 1'b0;
        endcase
    end

    // Shift the byte in big-endian
    assign shift_new     = {(shift_clear ? 24'd0 : shift_reg), s_axis_tdata};
    assign remaining_dec = (remaining_reg != 24'd0) ? remaining_reg - 24'd1 : 24'd0;

    // Next parse state
    always_comb
    begin
        phase_next     = phase_reg;
        index_next     = index_reg;
        shift_next     = shift_reg;
        sig_next       = sig_reg;
        version_next   = version_reg;
        flags_next     = flags_reg;
        tag_type_next  = tag_type_reg;
        data_size_next = data_size_reg;
        ts_next        = ts_reg;
        ts_ext_next    = ts_ext_reg;
        remaining_next = remaining_reg;
        if (in_fire)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    shift_next = shift_new[23:0];
                    case (index_reg)
                        4'd2:    sig_next     = shift_new[23:0];
                        4'd3:    version_next = s_axis_tdata;
                        4'd4:    flags_next   = s_axis_tdata;
                        default: ;
                    endcase
                    if (index_reg >= HEADER_LAST_IDX)
                    begin
                        phase_next = PH_PREV;
                        index_next = 4'd0;
                        shift_next = 24'd0;
                    end
                    else
                    begin
                        index_next = index_reg + 4'd1;
                    end
                end
                PH_PREV:
                begin
                    shift_next = shift_new[23:0];
                    if (index_reg >= PREV_LAST_IDX)
                    begin
                        phase_next = PH_TAG;
                        index_next = 4'd0;
                        shift_next = 24'd0;
                    end
                    else
                    begin
                        index_next = index_reg + 4'd1;
                    end
                end
                PH_TAG:
                begin
                    shift_next = shift_new[23:0];
                    case (index_reg)
                        4'd0:    tag_type_next  = s_axis_tdata;
                        4'd3:    data_size_next = shift_new[23:0];
                        4'd6:    ts_next        = shift_new[23:0];
                        4'd7:    ts_ext_next    = s_axis_tdata;
                        default: ;
                    endcase
                    if (index_reg >= TAG_LAST_IDX)
                    begin
                        remaining_next = data_size_reg;
                        phase_next     = (data_size_reg != 24'd0) ? PH_PAYLOAD : PH_PREV;
                        index_next     = 4'd0;
                        shift_next     = 24'd0;
                    end
                    else
                    begin
                        index_next = index_reg + 4'd1;
                    end
                end
                default:
                begin
                    remaining_next = remaining_dec;
                    if (remaining_dec == 24'd0)
                    begin
                        phase_next = PH_PREV;
                        index_next = 4'd0;
                        shift_next = 24'd0;
                    end
                end
            endcase
        end
    end

    // Build the result for the current byte
    always_comb
    begin
        out_next      = '0;
        out_next.kind = KIND_CONSUMED;
        case (phase_reg)
            PH_HEADER:
            begin
                if (index_reg >= HEADER_LAST_IDX)
                begin
                    out_next.kind          = KIND_HEADER;
                    out_next.signature     = sig_reg;
                    out_next.version       = version_reg;
                    out_next.flags         = flags_reg;
                    out_next.header_length = shift_new;
                end
            end
            PH_PREV:
            begin
                if (index_reg >= PREV_LAST_IDX)
                begin
                    out_next.kind          = KIND_PREV;
                    out_next.prev_tag_size = shift_new;
                end
            end
            PH_TAG:
            begin
                if (index_reg >= TAG_LAST_IDX)
                begin
                    out_next.kind      = KIND_TAG;
                    out_next.tag_type  = tag_type_reg;
                    out_next.data_size = data_size_reg;
                    out_next.timestamp = {ts_ext_reg, ts_reg};
                    out_next.stream_id = shift_new[23:0];
                end
            end
            default:
            begin
                out_next.kind         = KIND_PAYLOAD;
                out_next.payload_byte = s_axis_tdata;
                out_next.payload_last = (remaining_dec == 24'd0);
            end
        endcase
    end

    // Output register fills on accept, empties when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // Control and parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            index_reg     <= 4'd0;
            shift_reg     <= 24'd0;
            sig_reg       <= 24'd0;
            version_reg   <= 8'd0;
            flags_reg     <= 8'd0;
            tag_type_reg  <= 8'd0;
            data_size_reg <= 24'd0;
            ts_reg        <= 24'd0;
            ts_ext_reg    <= 8'd0;
            remaining_reg <= 24'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            index_reg     <= index_next;
            shift_reg     <= shift_next;
            sig_reg       <= sig_next;
            version_reg   <= version_next;
            flags_reg     <= flags_next;
            tag_type_reg  <= tag_type_next;
            data_size_reg <= data_size_next;
            ts_reg        <= ts_next;
            ts_ext_reg    <= ts_ext_next;
            remaining_reg <= remaining_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded on accept
    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.payload_last;
    assign m_axis_tdata  = {out_reg.payload_byte, out_reg.stream_id, out_reg.timestamp,
                            out_reg.data_size, out_reg.tag_type, out_reg.prev_tag_size,
                            out_reg.header_length, out_reg.flags, out_reg.version,
                            out_reg.signature};

endmodule
